### src/jrfb_pkg.sv
// Package for the joystick remote frame builder: mode and register codes,
// reset values, mapping constants and the mapped-axes type.
// No dependencies.
`default_nettype none

package jrfb_pkg;

  localparam logic [1:0] MD_ACT    = 2'd0;
  localparam logic [1:0] MD_DRIVE  = 2'd1;
  localparam logic [1:0] MD_ADJUST = 2'd2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_THR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_ID        = 3'd5;

  localparam logic [15:0] CENTER_X_RST     = 16'd2180;
  localparam logic [15:0] CENTER_Y_RST     = 16'd1960;
  localparam logic [11:0] DEAD_BAND_RST    = 12'd300;
  localparam logic [31:0] IDLE_TIMEOUT_RST = 32'd60000000;
  localparam logic [9:0]  DOWN_THR_RST     = 10'd315;
  localparam logic [7:0]  RX_ID_RST        = 8'd0;

  localparam logic [15:0] X_LOW  = 16'd630;
  localparam logic [15:0] X_HIGH = 16'd3730;
  localparam logic [15:0] Y_LOW  = 16'd310;
  localparam logic [15:0] Y_HIGH = 16'd3460;

  localparam logic [11:0] YAW_FULL   = 12'd1280;
  localparam logic [9:0]  PITCH_FULL = 10'd900;
  localparam logic [9:0]  PITCH_MID  = 10'd450;

  localparam logic [15:0] Q_FULL       = 16'd65280;
  localparam logic [15:0] BRIGHT_FLOOR = 16'd2048;
  localparam logic [15:0] ACC_RST      = 16'd32768;
  localparam logic [8:0]  VOL_DEAD     = 9'd54;
  localparam logic [10:0] YAW_DEAD     = 11'd153;
  localparam logic [15:0] VOL_ROUND    = 16'd45;
  localparam logic [18:0] PCT_ROUND    = 19'd1632;

  // Reciprocals, ceil(2^k / divisor): /155 k=27, /7 k=16, /90 k=22, /51 k=18
  localparam logic [19:0] YAW_RECIP   = 20'd865921;
  localparam logic [13:0] PITCH_RECIP = 14'd9363;
  localparam logic [15:0] VOL_RECIP   = 16'd46604;
  localparam logic [12:0] PCT_RECIP   = 13'd5141;

  typedef struct packed {
    logic signed [11:0] yaw;
    logic [9:0]         pitch;
    logic               active;
  } jrfb_axes_t;

endpackage

`default_nettype wire

### src/joystick_remote_frame_builder.sv
// Top level of the joystick remote frame builder: configuration registers,
// the tick pipeline, mode, quiet timer and tweak accumulators.
// Depends on jrfb_pkg and jrfb_map.
//
//   channel | role        | beat
//   in      | valid/ready | stick_x, stick_y, mode_press, side_held, stick_click, elapsed_us
//   out     | valid/ready | frame_target, yaw, pitch, mode_now, button_bits, sequence_res,
//           |             | volume_pct, bright_pct, going_idle
//   cfg     | write only  | cfg_we, cfg_index 0..5, cfg_data 32 bits
//
// One tick per cycle while the output is not held; a tick passes the input register
// (loaded at the accepting edge), then the mapping, ramp and frame registers
// before its frame is presented.
// An idle inactive tick leaves no frame and no state change.
// Reset clears configuration to defaults and all control state; no sweep.
// A held output backs up every stage to in_ready; up to three ticks queue behind it.
`default_nettype none

module joystick_remote_frame_builder (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [15:0]                       in_stick_x,
  input  wire logic [15:0]                       in_stick_y,
  input  wire logic                              in_mode_press,
  input  wire logic                              in_side_held,
  input  wire logic                              in_stick_click,
  input  wire logic [23:0]                       in_elapsed_us,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [7:0]                             out_frame_target,
  output logic signed [11:0]                     out_yaw,
  output logic [9:0]                             out_pitch,
  output logic [1:0]                             out_mode_now,
  output logic [1:0]                             out_button_bits,
  output logic [7:0]                             out_sequence_res,
  output logic [6:0]                             out_volume_pct,
  output logic [6:0]                             out_bright_pct,
  output logic                                   out_going_idle,
  input  wire logic                              cfg_we,
  input  wire logic [jrfb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [31:0]                       cfg_data
);
  import jrfb_pkg::*;

  function automatic logic [6:0] pct_of(input logic [15:0] acc);
    logic [18:0] n;
    logic [12:0] m;
    logic [24:0] prod;
    n    = {1'b0, acc, 2'b0} + {3'b0, acc} + PCT_ROUND;
    m    = n[18:6];
    prod = {12'b0, m} * {12'b0, PCT_RECIP};
    return prod[24:18];
  endfunction

  // configuration
  logic [15:0] center_x_r, center_y_r;
  logic [11:0] dead_band_r;
  logic [31:0] idle_timeout_r;
  logic [9:0]  down_thr_r;
  logic [7:0]  rx_id_r;

  // pipeline
  logic        s1_valid_r, s2_valid_r, s3_valid_r;
  logic [15:0] s1_x_r, s1_y_r;
  logic        s1_press_r, s1_side_r, s1_click_r;
  logic [23:0] s1_elapsed_r;
  jrfb_axes_t  map_axes;
  jrfb_axes_t  s2_axes_r, s3_axes_r;
  logic        s2_press_r, s2_side_r, s3_press_r, s3_side_r;
  logic [23:0] s2_elapsed_r, s3_elapsed_r;
  logic signed [10:0] s3_dvol_r, s3_dbri_r;

  // state
  logic [1:0]  mode_r, mode_nxt;
  logic [7:0]  seq_r;
  logic        idle_r;
  logic [31:0] quiet_r, quiet_nxt;
  logic [15:0] vol_acc_r, vol_acc_nxt, bri_acc_r, bri_acc_nxt;

  // output register
  logic        out_valid_r;

  // handshake
  logic emit, out_free, fire3, take, rdy2, rdy3, mv1, mv2;

  // ramp deltas
  logic signed [10:0] pd;
  logic [8:0]         apd;
  logic [15:0]        vn;
  logic [31:0]        vprod;
  logic [9:0]         vq;
  logic [10:0]        ay, ay1;
  logic signed [10:0] dvol, dbri;

  // frame stage
  logic [32:0]        quiet_sum;
  logic               leaving;
  logic signed [17:0] vol_sum, bri_sum;
  logic [15:0]        vol_clamped, bri_clamped;
  logic [1:0]         buttons;

  jrfb_map u_map (
    .stick_x     (s1_x_r),
    .stick_y     (s1_y_r),
    .mode_press  (s1_press_r),
    .side_held   (s1_side_r),
    .stick_click (s1_click_r),
    .center_x    (center_x_r),
    .center_y    (center_y_r),
    .dead_band   (dead_band_r),
    .axes        (map_axes)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r     <= CENTER_X_RST;
      center_y_r     <= CENTER_Y_RST;
      dead_band_r    <= DEAD_BAND_RST;
      idle_timeout_r <= IDLE_TIMEOUT_RST;
      down_thr_r     <= DOWN_THR_RST;
      rx_id_r        <= RX_ID_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X:     center_x_r     <= cfg_data[15:0];
        CFG_CENTER_Y:     center_y_r     <= cfg_data[15:0];
        CFG_DEAD_BAND:    dead_band_r    <= cfg_data[11:0];
        CFG_IDLE_TIMEOUT: idle_timeout_r <= cfg_data;
        CFG_DOWN_THR:     down_thr_r     <= cfg_data[9:0];
        CFG_RX_ID:        rx_id_r        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    emit     = ~idle_r | s3_axes_r.active;
    out_free = ~out_valid_r | out_ready;
    fire3    = s3_valid_r & (out_free | ~emit);
    take     = fire3 & emit;
    rdy3     = ~s3_valid_r | fire3;
    rdy2     = ~s2_valid_r | rdy3;
    in_ready = ~s1_valid_r | rdy2;
    mv1      = s1_valid_r & rdy2;
    mv2      = s2_valid_r & rdy3;
  end

  // ramp deltas from mapped axes
  always_comb begin
    pd    = $signed({1'b0, s2_axes_r.pitch}) - $signed({1'b0, PITCH_MID});
    apd   = pd[10] ? 9'(-pd) : pd[8:0];
    vn    = {apd, 7'b0} + VOL_ROUND;
    vprod = {16'b0, vn} * {16'b0, VOL_RECIP};
    vq    = vprod[31:22];
    if (apd > VOL_DEAD) begin
      dvol = pd[10] ? $signed(-{1'b0, vq}) : $signed({1'b0, vq});
    end else begin
      dvol = '0;
    end

    ay  = s2_axes_r.yaw[11] ? 11'(-s2_axes_r.yaw) : s2_axes_r.yaw[10:0];
    ay1 = ay + 11'd1;
    if (ay > YAW_DEAD) begin
      dbri = s2_axes_r.yaw[11] ? $signed(-{1'b0, ay1[10:1]}) : $signed({1'b0, ay1[10:1]});
    end else begin
      dbri = '0;
    end
  end

  // frame stage
  always_comb begin
    mode_nxt = mode_r;
    if (s3_press_r) begin
      case (mode_r)
        MD_ACT:   mode_nxt = MD_DRIVE;
        MD_DRIVE: mode_nxt = MD_ADJUST;
        default:  mode_nxt = MD_ACT;
      endcase
    end

    quiet_sum = {1'b0, quiet_r} + {9'b0, s3_elapsed_r};
    if (s3_axes_r.active) begin
      quiet_nxt = '0;
    end else if (quiet_sum[32]) begin
      quiet_nxt = '1;
    end else begin
      quiet_nxt = quiet_sum[31:0];
    end
    leaving = quiet_nxt > idle_timeout_r;

    vol_sum = $signed({2'b0, vol_acc_r}) + $signed({{7{s3_dvol_r[10]}}, s3_dvol_r});
    bri_sum = $signed({2'b0, bri_acc_r}) + $signed({{7{s3_dbri_r[10]}}, s3_dbri_r});

    if (vol_sum < 18'sd0) begin
      vol_clamped = '0;
    end else if (vol_sum > $signed({2'b0, Q_FULL})) begin
      vol_clamped = Q_FULL;
    end else begin
      vol_clamped = vol_sum[15:0];
    end

    if (bri_sum < $signed({2'b0, BRIGHT_FLOOR})) begin
      bri_clamped = BRIGHT_FLOOR;
    end else if (bri_sum > $signed({2'b0, Q_FULL})) begin
      bri_clamped = Q_FULL;
    end else begin
      bri_clamped = bri_sum[15:0];
    end

    vol_acc_nxt = (mode_nxt == MD_ADJUST) ? vol_clamped : vol_acc_r;
    bri_acc_nxt = (mode_nxt == MD_ADJUST) ? bri_clamped : bri_acc_r;

    buttons = {s3_side_r, (mode_nxt == MD_ACT) && (s3_axes_r.pitch <= down_thr_r)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MD_ACT;
      seq_r       <= '0;
      idle_r      <= 1'b0;
      quiet_r     <= '0;
      vol_acc_r   <= ACC_RST;
      bri_acc_r   <= ACC_RST;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (rdy2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (rdy3) begin
        s3_valid_r <= s2_valid_r;
      end
      if (take) begin
        out_valid_r <= 1'b1;
        mode_r      <= mode_nxt;
        seq_r       <= seq_r + 8'd1;
        idle_r      <= leaving;
        quiet_r     <= quiet_nxt;
        vol_acc_r   <= vol_acc_nxt;
        bri_acc_r   <= bri_acc_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_x_r       <= in_stick_x;
      s1_y_r       <= in_stick_y;
      s1_press_r   <= in_mode_press;
      s1_side_r    <= in_side_held;
      s1_click_r   <= in_stick_click;
      s1_elapsed_r <= in_elapsed_us;
    end
    if (mv1) begin
      s2_axes_r    <= map_axes;
      s2_press_r   <= s1_press_r;
      s2_side_r    <= s1_side_r;
      s2_elapsed_r <= s1_elapsed_r;
    end
    if (mv2) begin
      s3_axes_r    <= s2_axes_r;
      s3_press_r   <= s2_press_r;
      s3_side_r    <= s2_side_r;
      s3_elapsed_r <= s2_elapsed_r;
      s3_dvol_r    <= dvol;
      s3_dbri_r    <= dbri;
    end
    if (take) begin
      out_frame_target <= rx_id_r;
      out_yaw          <= s3_axes_r.yaw;
      out_pitch        <= s3_axes_r.pitch;
      out_mode_now     <= mode_nxt;
      out_button_bits  <= buttons;
      out_sequence_res <= seq_r;
      out_volume_pct   <= pct_of(vol_acc_nxt);
      out_bright_pct   <= pct_of(bri_acc_nxt);
      out_going_idle   <= leaving;
    end
  end

  assign out_valid = out_valid_r;

  a_seq_advances: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> seq_r == $past(seq_r) + 8'd1)
    else $error("frame counter did not advance on an emitted frame");

  a_idle_drop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (fire3 && !emit) |=> $stable(mode_r) && $stable(quiet_r) && $stable(idle_r)
      && $stable(vol_acc_r) && $stable(bri_acc_r) && $stable(seq_r))
    else $error("dropped idle tick changed state");

  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    vol_acc_r <= Q_FULL && bri_acc_r >= BRIGHT_FLOOR && bri_acc_r <= Q_FULL)
    else $error("tweak accumulator out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (take && out_valid_r) |-> out_ready)
    else $error("frame written over an untaken beat");

endmodule

`default_nettype wire

### src/jrfb_map.sv
// Stick mapping: activity detect, deadzone snap and linear map of both axes
// to saturated yaw and pitch. Purely combinational.
// Depends on jrfb_pkg.
`default_nettype none

module jrfb_map (
  input  wire logic [15:0]        stick_x,
  input  wire logic [15:0]        stick_y,
  input  wire logic               mode_press,
  input  wire logic               side_held,
  input  wire logic               stick_click,
  input  wire logic [15:0]        center_x,
  input  wire logic [15:0]        center_y,
  input  wire logic [11:0]        dead_band,
  output jrfb_pkg::jrfb_axes_t    axes
);
  import jrfb_pkg::*;

  logic signed [16:0] dx, dy;
  logic [15:0]        adx, ady;
  logic [15:0]        dz_ext;
  logic [15:0]        xs, ys;
  logic [11:0]        xt, yt;
  logic [18:0]        xn;
  logic [38:0]        xprod;
  logic [11:0]        xf;
  logic [12:0]        yn;
  logic [25:0]        yprod;

  always_comb begin
    dz_ext = {4'b0, dead_band};
    dx = $signed({1'b0, stick_x}) - $signed({1'b0, center_x});
    dy = $signed({1'b0, stick_y}) - $signed({1'b0, center_y});
    adx = dx[16] ? 16'(-dx) : dx[15:0];
    ady = dy[16] ? 16'(-dy) : dy[15:0];

    axes.active = mode_press | side_held | stick_click | (adx > dz_ext) | (ady > dz_ext);

    xs = (adx < dz_ext) ? center_x : stick_x;
    ys = (ady < dz_ext) ? center_y : stick_y;

    xt    = 12'(xs - X_LOW);
    xn    = {xt, 7'b0};
    xprod = {20'b0, xn} * {19'b0, YAW_RECIP};
    xf    = xprod[38:27];

    yt    = 12'(ys - Y_LOW);
    yn    = {yt, 1'b0};
    yprod = {13'b0, yn} * {12'b0, PITCH_RECIP};

    if (xs <= X_LOW) begin
      axes.yaw = $signed(YAW_FULL);
    end else if (xs >= X_HIGH) begin
      axes.yaw = $signed(-YAW_FULL);
    end else begin
      axes.yaw = $signed(YAW_FULL - xf);
    end

    if (ys <= Y_LOW) begin
      axes.pitch = '0;
    end else if (ys >= Y_HIGH) begin
      axes.pitch = PITCH_FULL;
    end else begin
      axes.pitch = yprod[25:16];
    end
  end

endmodule

`default_nettype wire

### test/joystick_remote_frame_builder_test.sv
// Self-checking bench for joystick_remote_frame_builder: queued tick driver, frame monitor
// and a cycle-free predictor of mode, quiet timer, axis mapping and tweak ramps.
// Depends on jrfb_pkg and the joystick_remote_frame_builder RTL.
`default_nettype none

module joystick_remote_frame_builder_test;
  import jrfb_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        press;
    logic        side;
    logic        click;
    logic [23:0] elapsed;
  } tick_t;

  typedef struct packed {
    logic [7:0]         target;
    logic signed [11:0] yaw;
    logic [9:0]         pitch;
    logic [1:0]         mode;
    logic [1:0]         buttons;
    logic [7:0]         seq;
    logic [6:0]         vol;
    logic [6:0]         bright;
    logic               going_idle;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_stick_x = '0;
  logic [15:0] in_stick_y = '0;
  logic in_mode_press = 1'b0;
  logic in_side_held = 1'b0;
  logic in_stick_click = 1'b0;
  logic [23:0] in_elapsed_us = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_frame_target;
  logic signed [11:0] out_yaw;
  logic [9:0] out_pitch;
  logic [1:0] out_mode_now;
  logic [1:0] out_button_bits;
  logic [7:0] out_sequence_res;
  logic [6:0] out_volume_pct;
  logic [6:0] out_bright_pct;
  logic out_going_idle;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  joystick_remote_frame_builder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_stick_x(in_stick_x), .in_stick_y(in_stick_y),
    .in_mode_press(in_mode_press), .in_side_held(in_side_held),
    .in_stick_click(in_stick_click), .in_elapsed_us(in_elapsed_us),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_frame_target(out_frame_target), .out_yaw(out_yaw), .out_pitch(out_pitch),
    .out_mode_now(out_mode_now), .out_button_bits(out_button_bits),
    .out_sequence_res(out_sequence_res), .out_volume_pct(out_volume_pct),
    .out_bright_pct(out_bright_pct), .out_going_idle(out_going_idle),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of configuration and state
  logic [15:0] center_x, center_y;
  logic [11:0] dead_band;
  logic [31:0] idle_limit;
  logic [9:0]  down_thr;
  logic [7:0]  rx_id;
  logic [1:0]  mode_cur;
  logic [7:0]  seq_cnt;
  logic        idle_state;
  logic [31:0] quiet_us;
  int          vol_acc, bright_acc;

  tick_t  tick_q[$];
  frame_t frame_q[$];
  tick_t  drv_tick, seen_tick;
  frame_t want, pred;
  int gap_pct = 0;
  int stall_pct = 0;
  int ticks_queued = 0;
  int ticks_taken = 0;
  int frames_checked = 0;
  int settings_used = 1;
  int mismatches = 0;
  int stuck_cycles = 0;
  logic in_taken = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int clamp_int(input int v, input int lo, input int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int round_away(input int num, input int den);
    int q;
    q = ((num < 0 ? -num : num) + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic logic [6:0] to_percent(input int acc);
    return 7'((longint'(acc) * 100 + int'(Q_FULL) / 2) / int'(Q_FULL));
  endfunction

  function automatic logic [15:0] clip16(input int v);
    return 16'(v < 0 ? 0 : (v > 65535 ? 65535 : v));
  endfunction

  function automatic logic [15:0] pick_axis();
    int r;
    r = $urandom_range(9);
    if (r < 6) return 16'($urandom_range(4095));
    if (r < 8) return 16'($urandom_range(65535));
    return (r == 8) ? 16'd0 : 16'hFFFF;
  endfunction

  // advance the remote by one tick; returns 1 with the frame when one is due
  function automatic bit advance_remote(input tick_t t, output frame_t f);
    int x, y, cx, cy, dz, ax, ay, d, yaw_v, pitch_v;
    longint yv, pv;
    bit active, leaving;
    logic [32:0] sum;
    x = int'(t.x); y = int'(t.y);
    cx = int'(center_x); cy = int'(center_y); dz = int'(dead_band);
    ax = x - cx; if (ax < 0) ax = -ax;
    ay = y - cy; if (ay < 0) ay = -ay;
    active = t.press || t.side || t.click || ax > dz || ay > dz;
    f = '0;
    if (idle_state) begin
      if (!active) return 1'b0;
      idle_state = 1'b0;
    end
    if (active) begin
      quiet_us = '0;
    end else begin
      sum = {1'b0, quiet_us} + 33'(t.elapsed);
      quiet_us = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end
    if (t.press) mode_cur = (mode_cur == MD_ADJUST) ? MD_ACT : mode_cur + 2'd1;
    if (x < cx + dz && x > cx - dz) x = cx;
    if (y < cy + dz && y > cy - dz) y = cy;
    yv = longint'(x - int'(X_LOW)) * (-2 * int'(YAW_FULL)) / (int'(X_HIGH) - int'(X_LOW))
         + int'(YAW_FULL);
    pv = longint'(y - int'(Y_LOW)) * int'(PITCH_FULL) / (int'(Y_HIGH) - int'(Y_LOW));
    yaw_v = yv > int'(YAW_FULL) ? int'(YAW_FULL)
          : (yv < -int'(YAW_FULL) ? -int'(YAW_FULL) : int'(yv));
    pitch_v = pv > int'(PITCH_FULL) ? int'(PITCH_FULL) : (pv < 0 ? 0 : int'(pv));
    f.buttons = {t.side, (mode_cur == MD_ACT) && (pitch_v <= int'(down_thr))};
    if (mode_cur == MD_ADJUST) begin
      d = pitch_v - int'(PITCH_MID);
      if (d > int'(VOL_DEAD) || d < -int'(VOL_DEAD))
        vol_acc = clamp_int(vol_acc + round_away(d * 128, 90), 0, int'(Q_FULL));
      if (yaw_v > int'(YAW_DEAD) || yaw_v < -int'(YAW_DEAD))
        bright_acc = clamp_int(bright_acc + round_away(yaw_v, 2), int'(BRIGHT_FLOOR),
                               int'(Q_FULL));
    end
    leaving = quiet_us > idle_limit;
    f.target = rx_id;
    f.yaw = 12'(yaw_v);
    f.pitch = 10'(pitch_v);
    f.mode = mode_cur;
    f.seq = seq_cnt;
    f.vol = to_percent(vol_acc);
    f.bright = to_percent(bright_acc);
    f.going_idle = leaving;
    seq_cnt = seq_cnt + 8'd1;
    if (leaving) idle_state = 1'b1;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic queue_tick(input logic [15:0] x, input logic [15:0] y, input logic press,
                            input logic side, input logic click, input logic [23:0] elapsed);
    tick_q.push_back('{x: x, y: y, press: press, side: side, click: click, elapsed: elapsed});
    ticks_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_CENTER_X:     center_x = val[15:0];
      CFG_CENTER_Y:     center_y = val[15:0];
      CFG_DEAD_BAND:    dead_band = val[11:0];
      CFG_IDLE_TIMEOUT: idle_limit = val;
      CFG_DOWN_THR:     down_thr = val[9:0];
      CFG_RX_ID:        rx_id = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] cx, input logic [15:0] cy,
                            input logic [11:0] dz, input logic [31:0] limit,
                            input logic [9:0] thr, input logic [7:0] tid);
    write_reg(CFG_CENTER_X, {16'($urandom_range(65535)), cx});
    write_reg(CFG_CENTER_Y, {16'($urandom_range(65535)), cy});
    write_reg(CFG_DEAD_BAND, {20'($urandom), dz});
    write_reg(CFG_IDLE_TIMEOUT, limit);
    write_reg(CFG_DOWN_THR, {22'($urandom), thr});
    write_reg(CFG_RX_ID, {24'($urandom), tid});
    write_reg(($urandom_range(1) != 0) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom);
    settings_used++;
  endtask

  // wait until every queued tick is taken and every frame has come back
  task automatic drain();
    while (ticks_taken != ticks_queued || frame_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // runs of held stick positions with random buttons, quiet runs and raw noise
  task automatic push_random(input int n);
    int made, len, style, bx, by, span;
    logic side;
    made = 0;
    while (made < n) begin
      style = $urandom_range(99);
      if (style < 10) begin
        queue_tick(16'($urandom), 16'($urandom), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 1'($urandom_range(1)), 24'($urandom));
        made++;
      end else if (style < 30) begin
        len = $urandom_range(8, 1);
        span = int'(dead_band);
        repeat (len) begin
          queue_tick(clip16(int'(center_x) + int'($urandom_range(2 * span)) - span),
                     clip16(int'(center_y) + int'($urandom_range(2 * span)) - span),
                     1'b0, 1'b0, 1'b0,
                     ($urandom_range(1) != 0) ? 24'($urandom) : 24'($urandom_range(50000)));
          made++;
        end
      end else begin
        len = $urandom_range(40, 1);
        bx = int'(pick_axis());
        by = int'(pick_axis());
        side = ($urandom_range(9) < 3);
        repeat (len) begin
          queue_tick(clip16(bx + int'($urandom_range(40)) - 20),
                     clip16(by + int'($urandom_range(40)) - 20),
                     ($urandom_range(19) == 0), side, ($urandom_range(19) < 3),
                     ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(40000)));
          made++;
        end
      end
    end
  endtask

  // driver: present the next tick when the channel is free
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
      if (!in_valid || in_taken) begin
        if (tick_q.size() > 0 && $urandom_range(99) >= gap_pct) begin
          drv_tick = tick_q.pop_front();
          in_stick_x <= drv_tick.x;
          in_stick_y <= drv_tick.y;
          in_mode_press <= drv_tick.press;
          in_side_held <= drv_tick.side;
          in_stick_click <= drv_tick.click;
          in_elapsed_us <= drv_tick.elapsed;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each frame beat, then predict from each accepted tick beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (frame_q.size() == 0) begin
          $error("frame beat with no frame expected: sequence_res %0d", out_sequence_res);
          mismatches++;
        end else begin
          want = frame_q.pop_front();
          check_field("frame_target", want.target, out_frame_target);
          check_field("yaw", want.yaw, out_yaw);
          check_field("pitch", want.pitch, out_pitch);
          check_field("mode_now", want.mode, out_mode_now);
          check_field("button_bits", want.buttons, out_button_bits);
          check_field("sequence_res", want.seq, out_sequence_res);
          check_field("volume_pct", want.vol, out_volume_pct);
          check_field("bright_pct", want.bright, out_bright_pct);
          check_field("going_idle", want.going_idle, out_going_idle);
          frames_checked++;
        end
      end
      if (in_valid && in_ready) begin
        seen_tick = '{x: in_stick_x, y: in_stick_y, press: in_mode_press,
                      side: in_side_held, click: in_stick_click, elapsed: in_elapsed_us};
        if (advance_remote(seen_tick, pred)) frame_q.push_back(pred);
        ticks_taken++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    center_x = CENTER_X_RST; center_y = CENTER_Y_RST; dead_band = DEAD_BAND_RST;
    idle_limit = IDLE_TIMEOUT_RST; down_thr = DOWN_THR_RST; rx_id = RX_ID_RST;
    mode_cur = MD_ACT; seq_cnt = '0; idle_state = 1'b0; quiet_us = '0;
    vol_acc = int'(ACC_RST); bright_acc = int'(ACC_RST);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed ticks at reset configuration
    queue_tick(16'd2180, 16'd1960, 1'b0, 1'b0, 1'b0, 24'd0);
    queue_tick(16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 24'd100);
    queue_tick(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 24'd100);
    queue_tick(16'd630, 16'd310, 1'b0, 1'b0, 1'b0, 24'd1);
    queue_tick(16'd3730, 16'd3460, 1'b0, 1'b0, 1'b0, 24'd1);
    queue_tick(16'd2480, 16'd1960, 1'b0, 1'b0, 1'b0, 24'd5);
    queue_tick(16'd2479, 16'd2259, 1'b0, 1'b0, 1'b0, 24'd5);
    queue_tick(16'd1880, 16'd1660, 1'b0, 1'b0, 1'b0, 24'd5);
    queue_tick(16'd2481, 16'd1960, 1'b0, 1'b0, 1'b0, 24'd5);
    queue_tick(16'd2180, 16'd1960, 1'b0, 1'b1, 1'b0, 24'd5);
    queue_tick(16'd2180, 16'd1960, 1'b0, 1'b0, 1'b1, 24'd5);
    queue_tick(16'd2180, 16'd0, 1'b1, 1'b0, 1'b0, 24'd5);
    queue_tick(16'd2180, 16'd1960, 1'b1, 1'b0, 1'b0, 24'd5);
    queue_tick(16'd2180, 16'hFFFF, 1'b0, 1'b0, 1'b0, 24'd5);
    queue_tick(16'd2180, 16'd0, 1'b0, 1'b0, 1'b0, 24'd5);
    queue_tick(16'd0, 16'd1960, 1'b0, 1'b0, 1'b0, 24'd5);
    queue_tick(16'hFFFF, 16'd1960, 1'b0, 1'b0, 1'b0, 24'd5);
    queue_tick(16'd2180, 16'd1960, 1'b0, 1'b1, 1'b0, 24'd5);
    queue_tick(16'd2180, 16'd1960, 1'b1, 1'b0, 1'b0, 24'd5);
    repeat (5) queue_tick(16'd2180, 16'd1960, 1'b0, 1'b0, 1'b0, 24'hFFFFFF);
    queue_tick(16'd2180, 16'd1960, 1'b0, 1'b0, 1'b1, 24'hFFFFFF);
    drain();

    push_random(230);
    drain();

    set_config(16'd2048, 16'd2048, 12'd0, 32'd0, 10'd900, 8'hFF);
    gap_pct = 84;
    push_random(230);
    drain();

    set_config(16'd0, 16'hFFFF, 12'hFFF, 32'hFFFF_FFFF, 10'd0, 8'h5A);
    gap_pct = 0;
    stall_pct = 84;
    push_random(115);
    repeat (270) queue_tick(center_x, center_y, 1'b0, 1'b0, 1'b0, 24'hFFFFFF);
    push_random(115);
    drain();

    set_config(16'hFFFF, 16'd0, 12'd1, 32'd1000, 10'd450, 8'd1);
    gap_pct = 15;
    stall_pct = 15;
    push_random(230);
    drain();

    set_config(16'($urandom_range(2800, 1500)), 16'($urandom_range(2800, 1500)),
               12'($urandom_range(600)), $urandom_range(50000000),
               10'($urandom_range(900)), 8'($urandom_range(255)));
    push_random(115);
    drain();
    push_random(115);
    drain();

    set_config(CENTER_X_RST, CENTER_Y_RST, DEAD_BAND_RST, IDLE_TIMEOUT_RST,
               DOWN_THR_RST, RX_ID_RST);
    gap_pct = 0;
    stall_pct = 0;
    push_random(230);
    drain();

    $display("Run covered %0d ticks and %0d frames across %0d register settings",
             ticks_taken, frames_checked, settings_used);
    $display("with sender gaps and receiver stalls; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
src/jrfb_pkg.sv
src/jrfb_map.sv
src/joystick_remote_frame_builder.sv
test/joystick_remote_frame_builder_test.sv
